FILE: hdl/u8u16_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 stream decoder.
`default_nettype none

package u8u16_pkg;

  localparam int unsigned CMDQ_DEPTH_DEFAULT = 4;

  localparam logic [7:0]  ASCII_LIMIT   = 8'h80;
  localparam logic [7:0]  LEAD2_BASE    = 8'hC0;
  localparam logic [7:0]  LEAD3_BASE    = 8'hE0;
  localparam logic [7:0]  LEAD4_BASE    = 8'hF0;
  localparam logic [7:0]  LEAD_LIMIT    = 8'hF8;
  localparam logic [7:0]  CONT_MASK     = 8'h3F;

  localparam logic [20:0] BMP_MAX       = 21'h00FFFF;
  localparam logic [20:0] SURR_FIRST    = 21'h00D800;
  localparam logic [20:0] SURR_LAST     = 21'h00DFFF;
  localparam logic [20:0] POINT_MAX     = 21'h10FFFF;
  localparam logic [20:0] SUPP_OFFSET   = 21'h010000;

  localparam logic [15:0] HIGH_SURR_BASE = 16'hD800;
  localparam logic [15:0] LOW_SURR_BASE  = 16'hDC00;
  localparam int unsigned SURR_BITS      = 10;  // 0x400 per surrogate half

  typedef enum logic {
    CMD_UNIT,  // one BMP code unit
    CMD_PAIR   // supplementary point, offset already removed
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [19:0] payload;
  } cmd_t;

endpackage

`default_nettype wire

FILE: hdl/utf8_to_utf16_stream_decoder_unit.sv
// Top level of the UTF-8 to UTF-16 stream decoder.
`default_nettype none

// Streams UTF-8 bytes in and UTF-16 code units out, both sides as queues.
// Push one byte per transfer while full is low; pop units while empty is
// low. A byte yields no unit (lead byte, stray continuation, rejected code
// point), one unit (ASCII or a completed BMP point) or two units (high then
// low surrogate, last_unit low on the high half). The front end takes one
// byte every cycle while the command queue has room; the emitter delivers
// one unit every cycle while units are popped, so a surrogate pair holds
// it for both halves and the command queue of CMDQ_DEPTH entries absorbs
// that. Full rises only once CMDQ_DEPTH commands wait. A byte's first unit
// passes through the command queue, then the output register. Continuation
// bytes are not checked for their top bits, and overlong forms are decoded
// as is. Surrogate points and points above 0x10FFFF are dropped silently.
module utf8_to_utf16_stream_decoder_unit
  import u8u16_pkg::*;
#(
  parameter int unsigned CMDQ_DEPTH = CMDQ_DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_byte,
  output logic             empty,
  input  wire logic        pop,
  output logic [15:0]      code_unit,
  output logic             last_unit
);

  logic byte_take;
  logic cmd_valid;
  cmd_t cmd_in;
  cmd_t cmd_out;
  logic cmd_empty;
  logic cmd_pop;

  // Accept a byte whenever the command queue has room for its result.
  assign byte_take = push && !full;

  u8u16_front u_front (
    .clk       (clk),
    .rst       (rst),
    .byte_take (byte_take),
    .in_byte   (in_byte),
    .cmd_valid (cmd_valid),
    .cmd       (cmd_in)
  );

  u8u16_cmdq #(
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_valid),
    .wr_data (cmd_in),
    .rd_en   (cmd_pop),
    .rd_data (cmd_out),
    .empty   (cmd_empty),
    .full    (full)
  );

  // Expand commands into units; advance on every pop transfer.
  u8u16_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .pop       (pop),
    .empty     (empty),
    .code_unit (code_unit),
    .last_unit (last_unit)
  );

endmodule

`default_nettype wire

FILE: hdl/u8u16_front.sv
// Front end: byte acceptance, sequence assembly and code point classification.
`default_nettype none

module u8u16_front
  import u8u16_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       byte_take,
  input  wire logic [7:0] in_byte,
  output logic            cmd_valid,
  output cmd_t            cmd
);

  logic [1:0]  pending_count;
  logic [1:0]  pending_count_next;
  logic [20:0] partial_point;
  logic [20:0] partial_point_next;
  logic [20:0] joined;
  logic [20:0] supp;

  assign joined = {partial_point[14:0], in_byte[5:0] & CONT_MASK[5:0]};
  assign supp   = joined - SUPP_OFFSET;

  always_comb begin
    pending_count_next = pending_count;
    partial_point_next = partial_point;
    cmd_valid          = 1'b0;
    cmd.kind           = CMD_UNIT;
    cmd.payload        = {12'd0, in_byte};
    if (byte_take) begin
      if (pending_count != 2'd0) begin
        pending_count_next = pending_count - 2'd1;
        partial_point_next = joined;
        if (pending_count == 2'd1) begin
          partial_point_next = '0;
          // Drop surrogate values and values beyond the code space.
          if (joined > POINT_MAX) begin
            cmd_valid = 1'b0;
          end else if (joined >= SURR_FIRST && joined <= SURR_LAST) begin
            cmd_valid = 1'b0;
          end else if (joined <= BMP_MAX) begin
            cmd_valid   = 1'b1;
            cmd.kind    = CMD_UNIT;
            cmd.payload = {4'd0, joined[15:0]};
          end else begin
            cmd_valid   = 1'b1;
            cmd.kind    = CMD_PAIR;
            cmd.payload = supp[19:0];
          end
        end
      end else if (in_byte < ASCII_LIMIT) begin
        cmd_valid = 1'b1;
      end else if (in_byte < LEAD2_BASE) begin
        cmd_valid = 1'b0;  // stray continuation byte
      end else if (in_byte < LEAD3_BASE) begin
        partial_point_next = {16'd0, in_byte[4:0]};
        pending_count_next = 2'd1;
      end else if (in_byte < LEAD4_BASE) begin
        partial_point_next = {17'd0, in_byte[3:0]};
        pending_count_next = 2'd2;
      end else if (in_byte < LEAD_LIMIT) begin
        partial_point_next = {18'd0, in_byte[2:0]};
        pending_count_next = 2'd3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_count <= 2'd0;
      partial_point <= '0;
    end else begin
      pending_count <= pending_count_next;
      partial_point <= partial_point_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/u8u16_cmdq.sv
// Command queue between the front end and the unit emitter.
`default_nettype none

module u8u16_cmdq
  import u8u16_pkg::*;
#(
  parameter int unsigned DEPTH = CMDQ_DEPTH_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_en,
  input  wire cmd_t wr_data,
  input  wire logic rd_en,
  output cmd_t      rd_data,
  output logic      empty,
  output logic      full
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  cmd_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign empty   = (count == '0);
  assign full    = (count == FULL_COUNT);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/u8u16_back.sv
// Back end: expands commands into UTF-16 units held in an output register.
`default_nettype none

module u8u16_back
  import u8u16_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cmd_empty,
  input  wire cmd_t        cmd,
  output logic             cmd_pop,
  input  wire logic        pop,
  output logic             empty,
  output logic [15:0]      code_unit,
  output logic             last_unit
);

  logic        out_valid;
  logic        out_valid_next;
  logic        low_due;
  logic        low_due_next;
  logic [15:0] code_unit_next;
  logic        last_unit_next;
  logic        can_load;

  assign empty    = !out_valid;
  assign can_load = !out_valid || pop;

  always_comb begin
    out_valid_next = out_valid;
    low_due_next   = low_due;
    code_unit_next = code_unit;
    last_unit_next = last_unit;
    cmd_pop        = 1'b0;
    if (can_load) begin
      out_valid_next = 1'b0;
      if (!cmd_empty) begin
        out_valid_next = 1'b1;
        if (cmd.kind == CMD_UNIT) begin
          code_unit_next = cmd.payload[15:0];
          last_unit_next = 1'b1;
          cmd_pop        = 1'b1;
        end else if (low_due) begin
          // Second half of the pair: retire the command.
          code_unit_next = LOW_SURR_BASE | {6'd0, cmd.payload[SURR_BITS-1:0]};
          last_unit_next = 1'b1;
          low_due_next   = 1'b0;
          cmd_pop        = 1'b1;
        end else begin
          code_unit_next = HIGH_SURR_BASE | {6'd0, cmd.payload[19:SURR_BITS]};
          last_unit_next = 1'b0;
          low_due_next   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      low_due   <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      low_due   <= low_due_next;
    end
  end

  always_ff @(posedge clk) begin
    code_unit <= code_unit_next;
    last_unit <= last_unit_next;
  end

endmodule

`default_nettype wire

FILE: hdl/u8u16_checker.sv
// Port-level checker for the stream decoder and its bind.
`default_nettype none

module u8u16_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        full,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [15:0] code_unit,
  input wire logic        last_unit
);

  a_reset_empty: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("decoder not idle after reset");

  a_hold_unit: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(code_unit) && $stable(last_unit)))
    else $error("waiting unit changed before transfer");

  a_high_half: assert property (@(posedge clk) disable iff (rst)
    (!empty && !last_unit) |-> (code_unit[15:10] == 6'b110110))
    else $error("non-final unit is not a high surrogate");

  a_low_follows: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !last_unit) |=>
      (!empty && last_unit && code_unit[15:10] == 6'b110111))
    else $error("high surrogate not followed by low surrogate");

  a_no_lone_high: assert property (@(posedge clk) disable iff (rst)
    (!empty && last_unit) |-> (code_unit[15:10] != 6'b110110))
    else $error("final unit is a high surrogate");

endmodule

bind utf8_to_utf16_stream_decoder_unit u8u16_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .full      (full),
  .empty     (empty),
  .pop       (pop),
  .code_unit (code_unit),
  .last_unit (last_unit)
);

`default_nettype wire

FILE: dv/utf8_to_utf16_stream_decoder_unit_test.sv
// Self-checking testbench for the UTF-8 to UTF-16 stream decoder.
module utf8_to_utf16_stream_decoder_unit_test;

  // Code point limits and surrogate bases, kept apart from the design package.
  localparam logic [20:0] BMP_TOP        = 21'h00FFFF;
  localparam logic [20:0] SURR_FIRST_PT  = 21'h00D800;
  localparam logic [20:0] SURR_LAST_PT   = 21'h00DFFF;
  localparam logic [20:0] MAX_POINT      = 21'h10FFFF;
  localparam logic [20:0] SUPP_BASE      = 21'h010000;
  localparam logic [15:0] HIGH_HALF_BASE = 16'hD800;
  localparam logic [15:0] LOW_HALF_BASE  = 16'hDC00;

  localparam int RANDOM_BYTES = 550;
  localparam int GAP_MAX      = 16;
  localparam int STALL_LIMIT  = 2000;  // cycles with no transfer on either side
  localparam int DRAIN_CYCLES = 20;    // catch stray units after the last one

  // One byte of stimulus. With fixed_units set, n_units/first/second are the
  // units typed in by hand; otherwise the decoder model supplies them.
  typedef struct {
    logic [7:0]  data;
    bit          fixed_units;
    int          n_units;
    logic [15:0] first;
    logic [15:0] second;
  } byte_row_t;

  typedef struct {
    logic [15:0] unit;
    logic        last;
  } utf16_unit_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  in_byte = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic [15:0] code_unit;
  logic        last_unit;

  // Directed bytes: field extremes, skipped bytes, each sequence length,
  // rejected points, overlong and unchecked continuation bytes.
  byte_row_t directed_rows [26] = '{
    '{8'h00, 1'b1, 1, 16'h0000, 16'h0000},  // NUL passes through as a unit
    '{8'h7F, 1'b1, 1, 16'h007F, 16'h0000},  // top of ASCII
    '{8'h80, 1'b1, 0, 16'h0000, 16'h0000},  // stray continuation, skipped
    '{8'hF8, 1'b1, 0, 16'h0000, 16'h0000},  // invalid lead, skipped
    '{8'hFF, 1'b1, 0, 16'h0000, 16'h0000},  // invalid lead, skipped
    '{8'hE2, 1'b0, 0, 16'h0000, 16'h0000},  // three-byte sequence
    '{8'h82, 1'b0, 0, 16'h0000, 16'h0000},
    '{8'hAC, 1'b0, 0, 16'h0000, 16'h0000},
    '{8'hED, 1'b1, 0, 16'h0000, 16'h0000},  // encoded surrogate, dropped
    '{8'hA0, 1'b1, 0, 16'h0000, 16'h0000},
    '{8'h80, 1'b1, 0, 16'h0000, 16'h0000},
    '{8'hF4, 1'b1, 0, 16'h0000, 16'h0000},  // point above the Unicode range
    '{8'h90, 1'b1, 0, 16'h0000, 16'h0000},
    '{8'h80, 1'b1, 0, 16'h0000, 16'h0000},
    '{8'h80, 1'b1, 0, 16'h0000, 16'h0000},
    '{8'hC0, 1'b0, 0, 16'h0000, 16'h0000},  // overlong NUL, still decoded
    '{8'h80, 1'b0, 0, 16'h0000, 16'h0000},
    '{8'hC3, 1'b0, 0, 16'h0000, 16'h0000},  // ASCII byte used as continuation
    '{8'h41, 1'b0, 0, 16'h0000, 16'h0000},
    '{8'hF4, 1'b1, 0, 16'h0000, 16'h0000},  // highest code point, pair
    '{8'h8F, 1'b1, 0, 16'h0000, 16'h0000},
    '{8'hBF, 1'b1, 0, 16'h0000, 16'h0000},
    '{8'hBF, 1'b1, 2, 16'hDBFF, 16'hDFFF},
    '{8'hEF, 1'b0, 0, 16'h0000, 16'h0000},  // highest BMP point
    '{8'hBF, 1'b0, 0, 16'h0000, 16'h0000},
    '{8'hBF, 1'b0, 0, 16'h0000, 16'h0000}
  };

  byte_row_t   cur_row;          // row on the input ports, driven with in_byte
  utf16_unit_t unit_q [$];       // units owed by the decoder, oldest first
  logic [1:0]  seq_left  = 2'd0; // continuation bytes still owed
  logic [20:0] point_acc = 21'd0;
  int          errors = 0;
  int          stall_cycles = 0;
  int          bytes_sent = 0;
  int          units_taken = 0;

  int          mon_n;
  logic [15:0] mon_first;
  logic [15:0] mon_second;
  utf16_unit_t mon_exp;

  utf8_to_utf16_stream_decoder_unit dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_byte   (in_byte),
    .empty     (empty),
    .pop       (pop),
    .code_unit (code_unit),
    .last_unit (last_unit)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the decoder state by one byte and return the units it yields.
  task automatic decode_byte(input logic [7:0] b, output int n,
                             output logic [15:0] first, output logic [15:0] second);
    logic [20:0] done_point;
    logic [20:0] offset;
    n = 0;
    first = 16'h0000;
    second = 16'h0000;
    if (seq_left != 2'd0) begin
      // Inside a sequence every byte counts as a continuation; top bits unchecked.
      point_acc = {point_acc[14:0], b[5:0]};
      seq_left = seq_left - 2'd1;
      if (seq_left == 2'd0) begin
        done_point = point_acc;
        point_acc = 21'd0;
        if (done_point > MAX_POINT ||
            (done_point >= SURR_FIRST_PT && done_point <= SURR_LAST_PT)) begin
          n = 0;
        end else if (done_point <= BMP_TOP) begin
          n = 1;
          first = done_point[15:0];
        end else begin
          offset = done_point - SUPP_BASE;
          n = 2;
          first = HIGH_HALF_BASE + {6'd0, offset[19:10]};
          second = LOW_HALF_BASE + {6'd0, offset[9:0]};
        end
      end
    end else if (b < 8'h80) begin
      n = 1;
      first = {8'h00, b};
    end else if (b < 8'hC0) begin
      n = 0;  // stray continuation
    end else if (b < 8'hE0) begin
      point_acc = {16'd0, b[4:0]};
      seq_left = 2'd1;
    end else if (b < 8'hF0) begin
      point_acc = {17'd0, b[3:0]};
      seq_left = 2'd2;
    end else if (b < 8'hF8) begin
      point_acc = {18'd0, b[2:0]};
      seq_left = 2'd3;
    end
  endtask

  // Present one byte after a random pause and hold it until the transfer.
  task automatic send_row(input byte_row_t row);
    int gap;
    // Run every fourth stretch of bytes back to back.
    gap = ((bytes_sent % 128) >= 96) ? 0 : $urandom_range(0, GAP_MAX);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_byte <= row.data;
    cur_row <= row;
    do @(posedge clk); while (full);
    bytes_sent++;
  endtask

  task automatic send_random(input logic [7:0] b);
    byte_row_t row;
    row = '{b, 1'b0, 0, 16'h0000, 16'h0000};
    send_row(row);
  endtask

  // Check each popped unit first, then log what an accepted byte owes, so a
  // unit can never be matched against the byte that is entering alongside it.
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) begin
        if (unit_q.size() == 0) begin
          $display("%0t: unit with none pending: expected none, actual %h last %b",
                   $time, code_unit, last_unit);
          errors++;
        end else begin
          mon_exp = unit_q.pop_front();
          if (code_unit !== mon_exp.unit) begin
            $display("%0t: code_unit expected %h actual %h", $time, mon_exp.unit, code_unit);
            errors++;
          end
          if (last_unit !== mon_exp.last) begin
            $display("%0t: last_unit expected %b actual %b", $time, mon_exp.last, last_unit);
            errors++;
          end
        end
      end
      if (push && !full) begin
        // Always step the model so its state tracks the stream; hand-typed
        // rows only override the units it reports.
        decode_byte(in_byte, mon_n, mon_first, mon_second);
        if (cur_row.fixed_units) begin
          mon_n = cur_row.n_units;
          mon_first = cur_row.first;
          mon_second = cur_row.second;
        end
        if (mon_n == 1) begin
          unit_q.insert(unit_q.size(), utf16_unit_t'{mon_first, 1'b1});
        end else if (mon_n == 2) begin
          unit_q.insert(unit_q.size(), utf16_unit_t'{mon_first, 1'b0});
          unit_q.insert(unit_q.size(), utf16_unit_t'{mon_second, 1'b1});
        end
      end
      if ((pop && !empty) || (push && !full)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Drain units with random back-pressure, holding pop high through bursts.
  initial begin : unit_sink
    int gap;
    @(negedge rst);
    forever begin
      gap = ((units_taken % 90) < 25) ? 0 : $urandom_range(0, GAP_MAX);
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      units_taken++;
    end
  end

  initial begin : byte_source
    int         kind;
    int         tail;
    bit         broken;
    logic [7:0] lead;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) send_row(directed_rows[i]);

    // Mostly well-formed sequences with random payload, plus broken sequences
    // (random tail bytes; a short tail eats the next lead) and raw noise bytes.
    while (bytes_sent < $size(directed_rows) + RANDOM_BYTES) begin
      kind = $urandom_range(0, 99);
      broken = 1'b0;
      if (kind < 20) begin
        lead = 8'($urandom_range(0, 127));
        tail = 0;
      end else if (kind < 35) begin
        lead = {3'b110, 5'($urandom)};
        tail = 1;
      end else if (kind < 55) begin
        lead = {4'b1110, 4'($urandom)};
        tail = 2;
      end else if (kind < 75) begin
        // Favor leads F0-F4 so most four-byte points land in range.
        lead = 8'hF0 | 8'($urandom_range(0, ($urandom_range(0, 3) == 0) ? 7 : 4));
        tail = 3;
      end else if (kind < 85) begin
        lead = 8'($urandom_range(8'hC0, 8'hF7));
        tail = $urandom_range(1, 3);
        broken = 1'b1;
      end else begin
        lead = 8'($urandom);
        tail = 0;
      end
      send_random(lead);
      repeat (tail) send_random(broken ? 8'($urandom) : {2'b10, 6'($urandom)});
    end
    push <= 1'b0;

    // Let the monitor log the last transfer before looking at what is owed.
    @(posedge clk);
    while (unit_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
